/* rtl/ggc_pkg.sv */
// Shared constants, operation codes and types for the greedy graph colorer.
`timescale 1ns / 1ps

package ggc_pkg;

   // Fixed field widths of the channels
   localparam int FUNC_W  = 2;
   localparam int ID_W    = 6;
   localparam int COLOR_W = 3;

   // Node ids the id field can reach
   localparam int ID_SPACE = 64;

   // Parameter defaults
   localparam int MAX_NODES_DEF    = 64;
   localparam int PALETTE_SIZE_DEF = 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Neighbor bits are folded into one color mask per group of eight nodes
   localparam int GRP = 8;

   // Operation codes carried in func
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD_NODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD_CONN = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RUN      = 2'd3;

   // Command handed from the front to the back
   typedef struct packed {
      logic [FUNC_W-1:0] op;
      logic [ID_W-1:0]   node_a;
      logic [ID_W-1:0]   node_b;
   } cmd_type;

endpackage

/* rtl/ggc_req_if.sv */
// Request channel: one graph operation per beat.
`timescale 1ns / 1ps

interface ggc_req_if;
   logic                       valid;
   logic                       ready;
   logic [ggc_pkg::FUNC_W-1:0] func;
   logic [ggc_pkg::ID_W-1:0]   node_a;
   logic [ggc_pkg::ID_W-1:0]   node_b;

   modport source (output valid, func, node_a, node_b, input ready);
   modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

/* rtl/ggc_rsp_if.sv */
// Response channel: one colored node per beat.
`timescale 1ns / 1ps

interface ggc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ggc_pkg::ID_W-1:0]    node_id;
   logic [ggc_pkg::COLOR_W-1:0] color;
   logic                        last;

   modport source (output valid, node_id, color, last, input ready);
   modport sink   (input valid, node_id, color, last, output ready);
endinterface

/* rtl/ggc_front.sv */
// Front end: accepts request beats, range checks ids and forwards useful commands.
`timescale 1ns / 1ps

module ggc_front #(
   parameter int MAX_NODES = ggc_pkg::MAX_NODES_DEF
) (
   ggc_req_if.sink          req_bus,
   output logic             push_valid,
   output ggc_pkg::cmd_type push_cmd,
   input  logic             push_ready
);

   logic a_ok;
   logic b_ok;
   logic keep;

   // Ids at or above the node count are dropped
   assign a_ok = 32'(req_bus.node_a) < MAX_NODES;
   assign b_ok = 32'(req_bus.node_b) < MAX_NODES;

   // Classify: out-of-range adds and connections are consumed without effect
   always_comb begin
      case (req_bus.func)
         ggc_pkg::FUNC_CLEAR:    keep = 1'b1;
         ggc_pkg::FUNC_ADD_NODE: keep = a_ok;
         ggc_pkg::FUNC_ADD_CONN: keep = a_ok & b_ok;
         ggc_pkg::FUNC_RUN:      keep = 1'b1;
         default:                keep = 1'b0;
      endcase
   end

   assign req_bus.ready   = push_ready;
   assign push_valid      = req_bus.valid & keep;
   assign push_cmd.op     = req_bus.func;
   assign push_cmd.node_a = req_bus.node_a;
   assign push_cmd.node_b = req_bus.node_b;

endmodule

/* rtl/ggc_queue.sv */
// Small command FIFO that decouples the front end from the coloring engine.
`timescale 1ns / 1ps

module ggc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  ggc_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             pop_valid,
   output ggc_pkg::cmd_type pop_cmd,
   input  logic             pop_ready
);

   localparam int DEPTH = ggc_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   ggc_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNTW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/ggc_back.sv */
// Coloring engine: holds the graph, applies commands and walks nodes during a run.
`timescale 1ns / 1ps

module ggc_back #(
   parameter int MAX_NODES    = ggc_pkg::MAX_NODES_DEF,
   parameter int PALETTE_SIZE = ggc_pkg::PALETTE_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   input  ggc_pkg::cmd_type pop_cmd,
   output logic             pop_ready,
   ggc_rsp_if.source        rsp_bus
);

   localparam int NODES = (MAX_NODES < ggc_pkg::ID_SPACE) ? MAX_NODES : ggc_pkg::ID_SPACE;
   localparam int NW    = $clog2(NODES);
   localparam int CW    = $clog2(PALETTE_SIZE);
   localparam int NG    = (NODES + ggc_pkg::GRP - 1) / ggc_pkg::GRP;
   localparam int CXW   = (CW > ggc_pkg::COLOR_W) ? CW : ggc_pkg::COLOR_W;
   localparam logic [NW-1:0] LAST_ID = NW'(NODES - 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CRA  = 3'd1;
   localparam logic [2:0] S_CWA  = 3'd2;
   localparam logic [2:0] S_CRB  = 3'd3;
   localparam logic [2:0] S_CWB  = 3'd4;
   localparam logic [2:0] S_SCAN = 3'd5;
   localparam logic [2:0] S_READ = 3'd6;
   localparam logic [2:0] S_PICK = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [NW-1:0]           v_ff, v_in;
   logic [NW-1:0]           a_ff;
   logic [NW-1:0]           b_ff;
   logic [NODES-1:0]        active_ff, active_in;
   logic [NODES-1:0]        row_vld_ff, row_vld_in;
   logic [NODES-1:0]        colored_ff, colored_in;
   logic [PALETTE_SIZE-1:0] part_ff [NG];
   logic [PALETTE_SIZE-1:0] part_in [NG];
   logic [CW-1:0]           color_ff [NODES];
   logic [NODES-1:0]        adj_mem [NODES];
   logic [NODES-1:0]        rdata_ff;
   logic                    rvld_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ggc_pkg::ID_W-1:0]    rsp_id_ff;
   logic [ggc_pkg::COLOR_W-1:0] rsp_color_ff;
   logic                    rsp_last_ff;

   logic                    take;
   logic [NW-1:0]           pop_a;
   logic [NW-1:0]           pop_b;
   logic                    rd_en;
   logic [NW-1:0]           rd_addr;
   logic                    wr_en;
   logic [NW-1:0]           wr_addr;
   logic [NODES-1:0]        wr_data;
   logic [NODES-1:0]        row_base;
   logic                    load_rsp;
   logic                    out_free;
   logic [PALETTE_SIZE-1:0] taken;
   logic [CW-1:0]           pick;
   logic [CXW-1:0]          pick_ext;
   logic [NODES-1:0]        above;
   logic                    last_bit;

   assign pop_a    = pop_cmd.node_a[NW-1:0];
   assign pop_b    = pop_cmd.node_b[NW-1:0];
   assign take     = pop_ready & pop_valid;
   assign row_base = rvld_ff ? rdata_ff : '0;
   assign out_free = ~rsp_valid_ff | rsp_bus.ready;

   // Fold colored neighbors of the fetched row into per-group color masks
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         part_in[g] = '0;
      end
      for (int u = 0; u < NODES; u++) begin
         if (rvld_ff && rdata_ff[u] && colored_ff[u]) begin
            part_in[u / ggc_pkg::GRP] = part_in[u / ggc_pkg::GRP]
                                        | (PALETTE_SIZE'(1) << color_ff[u]);
         end
      end
   end

   // Lowest free color; all taken falls back to zero
   always_comb begin
      taken = '0;
      for (int g = 0; g < NG; g++) begin
         taken = taken | part_ff[g];
      end
      pick = '0;
      for (int c = PALETTE_SIZE - 1; c >= 0; c--) begin
         if (!taken[c]) begin
            pick = CW'(c);
         end
      end
   end

   assign pick_ext = CXW'(pick);

   // Last flag: no active node above the current one
   always_comb begin
      for (int u = 0; u < NODES; u++) begin
         above[u] = u > int'(v_ff);
      end
   end

   assign last_bit = ~|(active_ff & above);

   // Command sequencer
   always_comb begin
      state_in   = state_ff;
      v_in       = v_ff;
      active_in  = active_ff;
      row_vld_in = row_vld_ff;
      colored_in = colored_ff;
      pop_ready  = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = v_ff;
      wr_en      = 1'b0;
      wr_addr    = a_ff;
      wr_data    = row_base | (NODES'(1) << b_ff);
      load_rsp   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               case (pop_cmd.op)
                  ggc_pkg::FUNC_CLEAR: begin
                     active_in  = '0;
                     row_vld_in = '0;
                     colored_in = '0;
                  end
                  ggc_pkg::FUNC_ADD_NODE: begin
                     active_in[pop_a] = 1'b1;
                  end
                  ggc_pkg::FUNC_ADD_CONN: begin
                     if (active_ff[pop_a] && active_ff[pop_b]) begin
                        state_in = S_CRA;
                     end
                  end
                  ggc_pkg::FUNC_RUN: begin
                     colored_in = '0;
                     v_in       = '0;
                     state_in   = S_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // Set bit b in row a, then bit a in row b
         S_CRA: begin
            rd_en    = 1'b1;
            rd_addr  = a_ff;
            state_in = S_CWA;
         end
         S_CWA: begin
            wr_en            = 1'b1;
            wr_addr          = a_ff;
            wr_data          = row_base | (NODES'(1) << b_ff);
            row_vld_in[a_ff] = 1'b1;
            state_in         = S_CRB;
         end
         S_CRB: begin
            rd_en    = 1'b1;
            rd_addr  = b_ff;
            state_in = S_CWB;
         end
         S_CWB: begin
            wr_en            = 1'b1;
            wr_addr          = b_ff;
            wr_data          = row_base | (NODES'(1) << a_ff);
            row_vld_in[b_ff] = 1'b1;
            state_in         = S_IDLE;
         end
         // Run: step through ids, fetch the row of each active one
         S_SCAN: begin
            if (active_ff[v_ff]) begin
               rd_en    = 1'b1;
               rd_addr  = v_ff;
               state_in = S_READ;
            end else if (v_ff == LAST_ID) begin
               state_in = S_IDLE;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         S_READ: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (out_free) begin
               load_rsp         = 1'b1;
               colored_in[v_ff] = 1'b1;
               if (v_ff == LAST_ID) begin
                  state_in = S_IDLE;
               end else begin
                  v_in     = v_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_bus.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v_ff         <= '0;
         active_ff    <= '0;
         row_vld_ff   <= '0;
         colored_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v_ff         <= v_in;
         active_ff    <= active_in;
         row_vld_ff   <= row_vld_in;
         colored_ff   <= colored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         a_ff <= pop_a;
         b_ff <= pop_b;
      end
      if (state_ff == S_READ) begin
         part_ff <= part_in;
      end
      if (load_rsp) begin
         color_ff[v_ff] <= pick;
         rsp_id_ff      <= ggc_pkg::ID_W'(v_ff);
         rsp_color_ff   <= pick_ext[ggc_pkg::COLOR_W-1:0];
         rsp_last_ff    <= last_bit;
      end
   end

   // Adjacency memory, one row per node, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= adj_mem[rd_addr];
         rvld_ff  <= row_vld_ff[rd_addr];
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.node_id = rsp_id_ff;
   assign rsp_bus.color   = rsp_color_ff;
   assign rsp_bus.last    = rsp_last_ff;

endmodule

/* rtl/greedy_graph_colorer_top.sv */
// Top level of the greedy graph colorer: front end, command queue and engine.
//
// Usage: the req channel carries one operation per beat (func 0 clear,
// 1 add node, 2 add connection, 3 run). Adds and connections with ids at
// or above MAX_NODES, and connections between nodes not both active, are
// taken and have no effect. A run returns one rsp beat per active node in
// ascending id order with its color; last marks the highest active node.
// A run on an empty graph returns nothing.
// Flow: request beats enter a four-entry command queue, so several can be
// taken while the engine is busy. A connection between two active nodes is a
// read-modify-write of two rows through the adjacency memory, in states CRA,
// CWA, CRB and CWB. A run visits each id in turn; for an active node it does
// the row fetch, the color mask fold and the color pick, in that order, and an
// inactive id is only stepped over.
// Reset (synchronous, active high) empties the graph and the queue; no
// clearing pass is needed. If rsp.ready is low the result register holds
// and the run waits; the queue keeps taking requests until it fills.
`timescale 1ns / 1ps

module greedy_graph_colorer_top #(
   parameter int MAX_NODES    = ggc_pkg::MAX_NODES_DEF,
   parameter int PALETTE_SIZE = ggc_pkg::PALETTE_SIZE_DEF
) (
   input logic       clock,
   input logic       reset,
   ggc_req_if.sink   req_bus,
   ggc_rsp_if.source rsp_bus
);

   logic             push_valid;
   ggc_pkg::cmd_type push_cmd;
   logic             push_ready;
   logic             pop_valid;
   ggc_pkg::cmd_type pop_cmd;
   logic             pop_ready;

   ggc_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   ggc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   ggc_back #(
      .MAX_NODES    (MAX_NODES),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* sim/ggc_color_checker.sv */
// Checker for the greedy graph colorer: watches both channels, predicts colorings, compares.
`timescale 1ns / 1ps

module ggc_color_checker #(
   parameter int MAX_NODES    = ggc_pkg::MAX_NODES_DEF,
   parameter int PALETTE_SIZE = ggc_pkg::PALETTE_SIZE_DEF
) (
   input  logic clock,
   input  logic reset,
   ggc_req_if   req_bus,
   ggc_rsp_if   rsp_bus,
   output int   mismatches,
   output int   pending
);
   import ggc_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]    node_id;
      logic [COLOR_W-1:0] color;
      logic               last;
   } colored_node_type;

   // Shadow copy of the graph
   logic [ID_SPACE-1:0] nbr_rows [ID_SPACE];
   logic [ID_SPACE-1:0] node_live;
   logic [ID_SPACE-1:0] node_done;
   int unsigned         node_hue [ID_SPACE];

   colored_node_type coloring_due[$];
   int               fail_count = 0;
   int               due_count  = 0;

   assign mismatches = fail_count;
   assign pending    = due_count;

   task automatic report_mismatch(input string what);
      $display("checker: %s", what);
      fail_count++;
   endtask

   task automatic wipe_graph();
      foreach (nbr_rows[i]) nbr_rows[i] = '0;
      node_live = '0;
      node_done = '0;
   endtask

   // Lowest palette index not held by an already colored neighbor; 0 if all are held
   function automatic int unsigned lowest_free_hue(input int v);
      logic [PALETTE_SIZE-1:0] held;
      held = '0;
      for (int u = 0; u < MAX_NODES && u < ID_SPACE; u++) begin
         if (nbr_rows[v][u] && node_done[u] && node_hue[u] < PALETTE_SIZE)
            held[node_hue[u]] = 1'b1;
      end
      for (int c = 0; c < PALETTE_SIZE; c++) begin
         if (!held[c])
            return c;
      end
      return 0;
   endfunction

   // One pass over the active nodes in ascending id order
   task automatic color_graph();
      int               highest;
      int unsigned      hue;
      colored_node_type beat;
      highest   = -1;
      node_done = '0;
      for (int v = 0; v < MAX_NODES && v < ID_SPACE; v++) begin
         if (node_live[v])
            highest = v;
      end
      if (highest < 0)
         return;
      for (int v = 0; v < MAX_NODES && v < ID_SPACE; v++) begin
         if (node_live[v]) begin
            hue          = lowest_free_hue(v);
            node_hue[v]  = hue;
            node_done[v] = 1'b1;
            beat.node_id = v[ID_W-1:0];
            beat.color   = hue[COLOR_W-1:0];
            beat.last    = (v == highest);
            coloring_due.insert(coloring_due.size(), beat);
         end
      end
   endtask

   task automatic apply_op(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b);
      case (op)
         FUNC_CLEAR: begin
            wipe_graph();
         end
         FUNC_ADD_NODE: begin
            if (a < MAX_NODES)
               node_live[a] = 1'b1;
         end
         FUNC_ADD_CONN: begin
            // both endpoints must already be active
            if (a < MAX_NODES && b < MAX_NODES && node_live[a] && node_live[b]) begin
               nbr_rows[a][b] = 1'b1;
               nbr_rows[b][a] = 1'b1;
            end
         end
         default: begin
            color_graph();
         end
      endcase
   endtask

   // Results are compared before the request of the same edge is applied:
   // a run never answers in the cycle it is taken.
   always @(posedge clock) begin
      colored_node_type want;
      if (reset) begin
         wipe_graph();
         coloring_due.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (coloring_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat: node %0d color %0d last %0b",
                                         rsp_bus.node_id, rsp_bus.color, rsp_bus.last));
            end else begin
               want = coloring_due.pop_front();
               if (rsp_bus.node_id !== want.node_id)
                  report_mismatch($sformatf("node_id %0d, expected %0d",
                                            rsp_bus.node_id, want.node_id));
               if (rsp_bus.color !== want.color)
                  report_mismatch($sformatf("node %0d: color %0d, expected %0d",
                                            want.node_id, rsp_bus.color, want.color));
               if (rsp_bus.last !== want.last)
                  report_mismatch($sformatf("node %0d: last %0b, expected %0b",
                                            want.node_id, rsp_bus.last, want.last));
            end
         end
         if (req_bus.valid && req_bus.ready)
            apply_op(req_bus.func, req_bus.node_a, req_bus.node_b);
      end
      due_count <= coloring_due.size();
   end

endmodule

/* sim/testbench.sv */
// Top of the greedy graph colorer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import ggc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_GOAL  = 105;

   logic clock;
   logic reset;

   ggc_req_if req_bus ();
   ggc_rsp_if rsp_bus ();

   int mismatches;
   int pending;
   int cycle_count = 0;
   bit calm        = 1'b0;

   // Stimulus-side view of which nodes exist, used to aim connections
   logic [ID_SPACE-1:0] stim_live = '0;
   int                  live_ids[$];
   int                  sent_ops = 0;

   greedy_graph_colorer_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ggc_color_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 36);
   end

   function automatic logic [ID_W-1:0] random_id(input bit wide);
      return wide ? ID_W'($urandom_range(0, ID_SPACE - 1)) : ID_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [FUNC_W-1:0] random_func();
      return FUNC_W'($urandom_range(0, 3));
   endfunction

   // Present one beat, with random gaps ahead of it, and wait for the handshake
   task automatic push_op(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] a,
                          input logic [ID_W-1:0] b);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.func   <= op;
      req_bus.node_a <= a;
      req_bus.node_b <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent_ops++;
      case (op)
         FUNC_CLEAR: begin
            stim_live = '0;
            live_ids.delete();
         end
         FUNC_ADD_NODE: begin
            if (!stim_live[a]) begin
               stim_live[a] = 1'b1;
               live_ids.insert(live_ids.size(), int'(a));
            end
         end
         default: begin
         end
      endcase
   endtask

   // Hold off the sender until every predicted result has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Clique of 9 or 10 nodes: the ninth node onward finds the palette full
   task automatic build_clique();
      int                  members[$];
      int                  target;
      int                  pick;
      logic [ID_SPACE-1:0] chosen;
      chosen = '0;
      target = 9 + $urandom_range(0, 1);
      push_op(FUNC_CLEAR, random_id(1), random_id(1));
      while (members.size() < target) begin
         pick = $urandom_range(0, ID_SPACE - 1);
         if (!chosen[pick]) begin
            chosen[pick] = 1'b1;
            members.insert(members.size(), pick);
         end
      end
      foreach (members[i]) push_op(FUNC_ADD_NODE, ID_W'(members[i]), random_id(1));
      for (int i = 0; i < members.size(); i++) begin
         for (int j = i + 1; j < members.size(); j++) begin
            if ($urandom_range(0, 1))
               push_op(FUNC_ADD_CONN, ID_W'(members[i]), ID_W'(members[j]));
            else
               push_op(FUNC_ADD_CONN, ID_W'(members[j]), ID_W'(members[i]));
         end
      end
      push_op(FUNC_RUN, random_id(1), random_id(1));
   endtask

   // Mostly well formed: optional clear, some nodes, links among them, usually one or two runs
   task automatic grow_random_graph();
      int nodes_to_add;
      int links;
      int a;
      int b;
      bit wide;
      wide = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0)
         push_op(FUNC_CLEAR, random_id(1), random_id(1));
      nodes_to_add = $urandom_range(1, 12);
      repeat (nodes_to_add) push_op(FUNC_ADD_NODE, random_id(wide), random_id(1));
      links = $urandom_range(0, 2 * nodes_to_add + 2);
      repeat (links) begin
         if ($urandom_range(0, 9) < 8 && live_ids.size() > 0) begin
            a = live_ids[$urandom_range(0, live_ids.size() - 1)];
            b = live_ids[$urandom_range(0, live_ids.size() - 1)];
         end else begin
            a = int'(random_id(wide));
            b = int'(random_id(wide));
         end
         push_op(FUNC_ADD_CONN, ID_W'(a), ID_W'(b));
         // stray operation inside the sequence
         if ($urandom_range(0, 19) == 0)
            push_op(random_func(), random_id(1), random_id(1));
      end
      if ($urandom_range(0, 6) != 0) begin
         push_op(FUNC_RUN, random_id(1), random_id(1));
         if ($urandom_range(0, 4) == 0)
            push_op(FUNC_RUN, random_id(1), random_id(1));
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 4))
         push_op(random_func(), random_id(1), random_id(1));
   endtask

   initial begin
      int seq;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.func   <= FUNC_CLEAR;
      req_bus.node_a <= '0;
      req_bus.node_b <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty runs, id extremes, self, inactive and repeated links
      push_op(FUNC_RUN, 0, 0);
      push_op(FUNC_ADD_NODE, 0, 63);
      push_op(FUNC_ADD_NODE, 63, 0);
      push_op(FUNC_ADD_CONN, 0, 63);
      push_op(FUNC_ADD_CONN, 63, 63);
      push_op(FUNC_ADD_CONN, 0, 5);
      push_op(FUNC_ADD_NODE, 0, 0);
      push_op(FUNC_ADD_CONN, 63, 0);
      push_op(FUNC_RUN, 63, 63);
      push_op(FUNC_CLEAR, 63, 63);
      push_op(FUNC_RUN, 0, 0);
      // triangle on 42 and 21 (alternating bit patterns) and 7, run twice
      push_op(FUNC_ADD_NODE, 42, 21);
      push_op(FUNC_ADD_NODE, 21, 42);
      push_op(FUNC_ADD_NODE, 7, 0);
      push_op(FUNC_ADD_CONN, 21, 42);
      push_op(FUNC_ADD_CONN, 7, 21);
      push_op(FUNC_ADD_CONN, 42, 7);
      push_op(FUNC_RUN, 0, 0);
      push_op(FUNC_RUN, 21, 42);

      // Random sequences; sequences 3 and 4 without any idling on either side
      sent_ops = 0;
      seq      = 0;
      while (sent_ops < RANDOM_GOAL) begin
         calm <= (seq == 3 || seq == 4);
         if (seq == 0) begin
            build_clique();
            wait_for_results();
         end else begin
            case ($urandom_range(0, 9))
               0:       noise_burst();
               default: grow_random_graph();
            endcase
         end
         seq++;
      end
      calm <= 1'b0;

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

/* greedy_graph_colorer_top.f */
rtl/ggc_pkg.sv
rtl/ggc_req_if.sv
rtl/ggc_rsp_if.sv
rtl/ggc_front.sv
rtl/ggc_queue.sv
rtl/ggc_back.sv
rtl/greedy_graph_colorer_top.sv
sim/ggc_color_checker.sv
sim/testbench.sv
